/* hw/rtl/cls_pkg.sv */
// Shared types and constants for the compacting list store.
// Holds action and status codes, the cell control struct and the state encoding.
// No dependencies.
package cls_pkg;

  // Action codes carried in the input transfer
  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_WRITE  = 2'd2;
  localparam logic [1:0] ACT_REMOVE = 2'd3;

  // Status codes returned with each result
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Bit pattern of -1.0, returned on a read with a bad index
  localparam logic [31:0] RD_ERR_WORD = 32'hBF80_0000;

  localparam int WORD_W  = 32;
  localparam int IDX_W   = 8;
  localparam int FILL_W  = 9;
  // Cells folded into one register of the read tree
  localparam int GRP_SZ  = 16;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic do_wr;   // overwrite the cell at idx
    logic do_app;  // load the cell at count
    logic do_rem;  // cells at and above idx take their upper neighbor
  } cls_cell_ctl_t;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RED  = 3'b010,
    S_OUT  = 3'b100
  } cls_state_t;

endpackage

/* hw/rtl/cls_cell.sv */
// One storage cell of the list chain: holds one word.
// Loads the new word, takes its upper neighbor on a remove, or holds.
// Depends on cls_pkg.
module cls_cell
  import cls_pkg::*;
#(
  parameter int CW       = 9,
  parameter int CELL_IDX = 0
) (
  input  logic              clk,
  input  cls_cell_ctl_t     ctl,
  input  logic [CW-1:0]     idx,
  input  logic [CW-1:0]     cnt,
  input  logic [WORD_W-1:0] new_word,
  input  logic [WORD_W-1:0] nbr_word,
  output logic [WORD_W-1:0] word,
  output logic [WORD_W-1:0] rd_word
);

  localparam logic [CW-1:0] MY_POS = CW'(CELL_IDX);

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;
  logic              hit;

  assign hit = (idx == MY_POS);

  // Pick the next word for this cell
  always_comb begin
    word_nxt = word_r;
    if ((ctl.do_wr && hit) || (ctl.do_app && (cnt == MY_POS))) begin
      word_nxt = new_word;
    end else if (ctl.do_rem && (MY_POS >= idx)) begin
      word_nxt = nbr_word;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word    = word_r;
  // Gate the stored word onto the read tree when addressed
  assign rd_word = word_r & {WORD_W{hit}};

endmodule

/* hw/rtl/cls_rd_tree.sv */
// Registered OR tree that collects the addressed cell's word.
// First level folds groups of cells into registers, second level ORs the groups.
// Depends on cls_pkg.
module cls_rd_tree
  import cls_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic              clk,
  input  logic              en,
  input  logic [WORD_W-1:0] cell_rd [DEPTH],
  output logic [WORD_W-1:0] rd_word
);

  localparam int NGRP = (DEPTH + GRP_SZ - 1) / GRP_SZ;

  logic [WORD_W-1:0] grp_r   [NGRP];
  logic [WORD_W-1:0] grp_nxt [NGRP];

  // Fold each group of cells
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int c = 0; c < GRP_SZ; c++) begin
        if (g * GRP_SZ + c < DEPTH) begin
          grp_nxt[g] = grp_nxt[g] | cell_rd[g * GRP_SZ + c];
        end
      end
    end
  end

  // Capture group results on an accepted transfer
  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  // Combine the groups
  always_comb begin
    rd_word = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_word = rd_word | grp_r[g];
    end
  end

endmodule

/* hw/rtl/compacting_list_store.sv */
// Compacting list store: an ordered list of up to DEPTH 32-bit words held in a chain of cells,
// with append, read, write and remove-with-compaction; each input transfer yields one result.
// Each item runs in order: the accept cycle updates all cells together (a remove shifts every
// later cell down in that same cycle), the next cycle settles the read through the second level
// of the registered read tree and loads the output register, and the result is valid from the
// cycle after that until taken; a new item is taken in the cycle after the result transfer, so
// a stalled result holds off the next item. An index at or beyond the count gives status 1
// (and 0xBF800000 on a read); an append to a full list is dropped with status 2. No clearing
// pass is needed after reset.
module compacting_list_store
  import cls_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] action, [9:2] index, [41:10] word_value, [47:42] zero
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] read_word, [33:32] status, [42:34] fill_count, [47:43] zero
  output logic [47:0] out_tdata
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cls_state_t state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [1:0]        st_r, st_nxt;
  logic              rd_ok_r, rd_err_r;
  logic [47:0]       out_data_r;

  logic [1:0]        act;
  logic [IDX_W-1:0]  idx_in;
  logic [WORD_W-1:0] word_in;
  logic [XW-1:0]     idx_x, cnt_x;
  logic              in_range, full, acc;
  cls_cell_ctl_t     ctl;
  logic [CW-1:0]     idx_c;

  logic [WORD_W-1:0] cell_word [DEPTH];
  logic [WORD_W-1:0] cell_rd   [DEPTH];
  logic [WORD_W-1:0] tree_word;
  logic [WORD_W-1:0] res_word;

  // Unpack the input transfer
  assign act     = in_tdata[1:0];
  assign idx_in  = in_tdata[9:2];
  assign word_in = in_tdata[41:10];

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;

  assign idx_x    = XW'(idx_in);
  assign cnt_x    = XW'(cnt_r);
  assign in_range = (idx_x < cnt_x);
  assign full     = (cnt_r == FULL_CNT);
  assign idx_c    = CW'(idx_x);

  // Decode the broadcast command
  always_comb begin
    ctl.do_wr  = acc && (act == ACT_WRITE) && in_range;
    ctl.do_app = acc && (act == ACT_APPEND) && !full;
    ctl.do_rem = acc && (act == ACT_REMOVE) && in_range;
  end

  // Chain of cells, each fed by its upper neighbor
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [WORD_W-1:0] nbr;
    if (k == DEPTH - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_word[k + 1];
    end
    cls_cell #(
      .CW       (CW),
      .CELL_IDX (k)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .idx      (idx_c),
      .cnt      (cnt_r),
      .new_word (word_in),
      .nbr_word (nbr),
      .word     (cell_word[k]),
      .rd_word  (cell_rd[k])
    );
  end

  cls_rd_tree #(
    .DEPTH (DEPTH)
  ) u_rd_tree (
    .clk     (clk),
    .en      (acc),
    .cell_rd (cell_rd),
    .rd_word (tree_word)
  );

  // Next count and status
  always_comb begin
    cnt_nxt = cnt_r;
    st_nxt  = st_r;
    if (acc) begin
      st_nxt = ST_OK;
      case (act)
        ACT_APPEND: begin
          if (full) begin
            st_nxt = ST_FULL;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        ACT_REMOVE: begin
          if (in_range) begin
            cnt_nxt = cnt_r - CW'(1);
          end else begin
            st_nxt = ST_RANGE;
          end
        end
        default: begin
          if (!in_range) begin
            st_nxt = ST_RANGE;
          end
        end
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (acc) state_nxt = S_RED;
      S_RED:  state_nxt = S_OUT;
      S_OUT:  if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      st_r    <= st_nxt;
    end
  end

  // Hold read qualifiers for the settle cycle
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_ok_r  <= (act == ACT_READ) && in_range;
      rd_err_r <= (act == ACT_READ) && !in_range;
    end
  end

  always_comb begin
    res_word = '0;
    if (rd_ok_r) begin
      res_word = tree_word;
    end else if (rd_err_r) begin
      res_word = RD_ERR_WORD;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (state_r == S_RED) begin
      out_data_r <= {5'd0, FILL_W'(cnt_r), st_r, res_word};
    end
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = out_data_r;

  // Count never passes the depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("list count beyond depth");

  // An in-range remove drops the count by one
  a_rem_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && act == ACT_REMOVE && in_range) |=> (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("remove did not shrink the list");

  // A full status only leaves with a full list
  a_full_st: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[33:32] == ST_FULL) |-> full)
    else $error("full status with room left");

  // A failed read returns the error word
  a_rd_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && rd_err_r) |-> (out_tdata[31:0] == RD_ERR_WORD))
    else $error("read error word missing");

  // No transfer is taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while result pending");

endmodule
